// ----- rtl/cts_pkg.sv -----
// Package for the cooldown task scheduler: sizes, limits and the queue entry type.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cts_pkg;

    // Job limits
    localparam int NUM_KINDS = 26;
    localparam int MAX_TASKS = 4096;

    // Field widths
    localparam int LETTER_W = 5;
    localparam int CD_W     = 8;
    localparam int LEN_W    = 21;

    // Derived widths
    localparam int KIND_W  = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int TIES_W  = $clog2(NUM_KINDS + 1);
    localparam int PROD_W  = CNT_W + CD_W + 1;
    localparam int FRAME_W = PROD_W + 1;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Queue between the front and back parts
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // One classified request as it travels through the queue
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              known;
        logic              last;
    } cts_entry_t;

endpackage

// ----- rtl/cts_if.sv -----
// Handshake interfaces of the cooldown task scheduler: tasks, results and configuration.
// Depends on cts_pkg for the field widths.
`timescale 1ns / 1ps

// Task requests: one letter per request, last marks the end of a job
interface cts_task_if;
    import cts_pkg::*;
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] task_letter;
    logic                last_task;
    modport source (output valid, output task_letter, output last_task, input ready);
    modport sink   (input valid, input task_letter, input last_task, output ready);
endinterface

// Results: one per job
interface cts_result_if;
    import cts_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] schedule_length;
    logic             overflow;
    modport source (output valid, output schedule_length, output overflow, input ready);
    modport sink   (input valid, input schedule_length, input overflow, output ready);
endinterface

// Configuration write channel for the cooldown register
interface cts_cfg_if;
    import cts_pkg::*;
    logic            valid;
    logic            ready;
    logic [CD_W-1:0] cooldown;
    modport source (output valid, output cooldown, input ready);
    modport sink   (input valid, input cooldown, output ready);
endinterface

// ----- rtl/cts_front.sv -----
// Front part: accepts task requests, classifies the letter and holds one entry for the queue.
// Depends on cts_pkg and cts_task_if.
`timescale 1ns / 1ps

module cts_front (
    input  logic                clk,
    input  logic                rst_n,
    cts_task_if.sink            task_in,
    output logic                push,
    output cts_pkg::cts_entry_t push_entry,
    input  logic                full
);
    import cts_pkg::*;

    logic       hold_valid_reg, hold_valid_next;
    cts_entry_t entry_reg, entry_next;
    logic       take;
    logic       moved;

    // A new request may enter when the holding stage is empty or drains this cycle
    assign task_in.ready = !hold_valid_reg || !full;
    assign take          = task_in.valid && task_in.ready;
    assign moved         = hold_valid_reg && !full;

    // Classify the letter: only letters below the number of kinds are counted
    always_comb
    begin
        entry_next      = entry_reg;
        hold_valid_next = hold_valid_reg;
        if (moved)
        begin
            hold_valid_next = 1'b0;
        end
        if (take)
        begin
            hold_valid_next  = 1'b1;
            entry_next.kind  = KIND_W'(task_in.task_letter);
            entry_next.known = (32'(task_in.task_letter) < NUM_KINDS);
            entry_next.last  = task_in.last_task;
        end
    end

    assign push       = hold_valid_reg;
    assign push_entry = entry_reg;

    // Holding stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Holding stage payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/cts_queue.sv -----
// Short first-in first-out queue that decouples the front part from the back part.
// Depends on cts_pkg for the entry type and depth.
`timescale 1ns / 1ps

module cts_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cts_pkg::cts_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output cts_pkg::cts_entry_t head,
    output logic                empty
);
    import cts_pkg::*;

    cts_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/cts_back.sv -----
// Back part: per-letter histogram, end-of-job scan, length arithmetic and the result register.
// Depends on cts_pkg, cts_cfg_if and cts_result_if.
`timescale 1ns / 1ps

module cts_back (
    input  logic                clk,
    input  logic                rst_n,
    output logic                pop,
    input  cts_pkg::cts_entry_t head,
    input  logic                empty,
    cts_cfg_if.sink             cfg,
    cts_result_if.source        result
);
    import cts_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    counts_reg [NUM_KINDS];
    logic [CNT_W-1:0]    counts_next [NUM_KINDS];
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic                ovf_reg, ovf_next;
    logic [CD_W-1:0]     cooldown_reg, cooldown_next;
    logic [KIND_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]    top_reg, top_next;
    logic [TIES_W-1:0]   ties_reg, ties_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic                out_ovf_reg, out_ovf_next;
    logic [CNT_W-1:0]    scan_count;
    logic [FRAME_W-1:0]  frame;
    logic [FRAME_W-1:0]  total_f;
    logic [LEN_W-1:0]    length;
    logic                out_free;

    assign cfg.ready              = 1'b1;
    assign result.valid           = out_valid_reg;
    assign result.schedule_length = out_len_reg;
    assign result.overflow        = out_ovf_reg;

    assign out_free   = !out_valid_reg || result.ready;
    assign pop        = (state_reg == ST_LOAD) && !empty;
    assign scan_count = counts_reg[0];

    // Final length: the larger of the frame and the task total, saturated; zero for an empty job
    always_comb
    begin
        frame   = FRAME_W'(prod_reg) + FRAME_W'(ties_reg);
        total_f = FRAME_W'(loaded_reg);
        if (frame < total_f)
        begin
            frame = total_f;
        end
        if (loaded_reg == '0)
        begin
            length = '0;
        end
        else if (frame > FRAME_W'(LEN_MAX))
        begin
            length = LEN_MAX;
        end
        else
        begin
            length = LEN_W'(frame);
        end
    end

    // Sequencer: load requests, shift the histogram out past the scan, multiply, finish
    always_comb
    begin
        state_next     = state_reg;
        counts_next    = counts_reg;
        loaded_next    = loaded_reg;
        ovf_next       = ovf_reg;
        cooldown_next  = cfg.valid ? cfg.cooldown : cooldown_reg;
        scan_next      = scan_reg;
        top_next       = top_reg;
        ties_next      = ties_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (!empty)
                begin
                    if (head.known)
                    begin
                        if (loaded_reg < CNT_W'(MAX_TASKS))
                        begin
                            counts_next[head.kind] = counts_reg[head.kind] + CNT_W'(1);
                            loaded_next            = loaded_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (head.last)
                    begin
                        state_next = ST_SCAN;
                        scan_next  = '0;
                        top_next   = '0;
                        ties_next  = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                // Oldest count leaves at the bottom, zero enters at the top
                for (int k = 0; k < NUM_KINDS - 1; k++)
                begin
                    counts_next[k] = counts_reg[k + 1];
                end
                counts_next[NUM_KINDS - 1] = '0;
                if (scan_count > top_reg)
                begin
                    top_next  = scan_count;
                    ties_next = TIES_W'(1);
                end
                else if ((scan_count != '0) && (scan_count == top_reg))
                begin
                    ties_next = ties_reg + TIES_W'(1);
                end
                if (scan_reg == KIND_W'(NUM_KINDS - 1))
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    scan_next = scan_reg + KIND_W'(1);
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(top_reg - CNT_W'(1)) *
                             PROD_W'({1'b0, cooldown_reg} + 9'd1);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = length;
                    out_ovf_next   = ovf_reg;
                    loaded_next    = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control state, histogram and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            counts_reg    <= '{default: '0};
            loaded_reg    <= '0;
            ovf_reg       <= 1'b0;
            cooldown_reg  <= '0;
            scan_reg      <= '0;
            top_reg       <= '0;
            ties_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counts_reg    <= counts_next;
            loaded_reg    <= loaded_next;
            ovf_reg       <= ovf_next;
            cooldown_reg  <= cooldown_next;
            scan_reg      <= scan_next;
            top_reg       <= top_next;
            ties_reg      <= ties_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Arithmetic and result payload
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        out_len_reg <= out_len_next;
        out_ovf_reg <= out_ovf_next;
    end

`ifndef SYNTHESIS
    // The job never holds more tasks than the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above limit");

    // The scan leaves the bottom and top histogram entries empty for the next job.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (counts_reg[0] == '0) && (counts_reg[NUM_KINDS - 1] == '0))
        else $error("histogram not cleared after scan");

    // The largest count cannot exceed the task total, and ties only exist with a top count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (top_reg <= loaded_reg) &&
            ((top_reg == '0) == (ties_reg == '0)))
        else $error("inconsistent top count or ties");
`endif

endmodule

// ----- rtl/cooldown_task_schedule_length.sv -----
// Top level of the cooldown task scheduler: front part, queue and back part.
// Depends on cts_pkg, cts_if, cts_front, cts_queue and cts_back.
// Throughput: one task request per cycle within a job while the queue has room; the histogram takes one update a cycle.
// A job end takes the back part through the histogram scan, the multiply and the finish step.
// Reset: asynchronous, clears histogram, counters, cooldown and queue at once; no clearing pass.
`timescale 1ns / 1ps

module cooldown_task_schedule_length (
    input  logic         clk,
    input  logic         rst_n,
    cts_task_if.sink     task_in,
    cts_cfg_if.sink      cfg,
    cts_result_if.source result
);
    import cts_pkg::*;

    logic       push;
    cts_entry_t push_entry;
    logic       full;
    logic       pop;
    cts_entry_t head;
    logic       empty;

    // Accept and classify requests
    cts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_in    (task_in),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    // Decoupling queue
    cts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    // Histogram and schedule length
    cts_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .pop    (pop),
        .head   (head),
        .empty  (empty),
        .cfg    (cfg),
        .result (result)
    );

endmodule

// ----- tb/tb_cooldown_task_schedule_length.sv -----
// Self-checking testbench for cooldown_task_schedule_length: directed and random jobs with
// random idling on both sides, each result checked against a built-in schedule predictor.
// Depends on rtl/cts_pkg.sv, rtl/cts_if.sv and the block's RTL.
`timescale 1ns / 1ps

module tb_cooldown_task_schedule_length;

    import cts_pkg::*;

    localparam int IDLE_MAX   = 13;
    localparam int SETTLE_CYC = 40;
    localparam int STALL_CAP  = 4000;
    localparam int LONG_JOB   = 300;
    localparam int SWEEP_LEN  = 110;

    // Letter indices used by the directed jobs
    localparam logic [LETTER_W-1:0] LT_A   = 5'd0;
    localparam logic [LETTER_W-1:0] LT_B   = 5'd1;
    localparam logic [LETTER_W-1:0] LT_C   = 5'd2;
    localparam logic [LETTER_W-1:0] LT_Z   = 5'd25;
    localparam logic [LETTER_W-1:0] LT_OUT = 5'd26;
    localparam logic [LETTER_W-1:0] LT_TOP = 5'd31;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             overflow;
    } job_result_t;

    logic clk;
    logic rst_n;

    cts_task_if   task_ch ();
    cts_cfg_if    cfg_ch ();
    cts_result_if result_ch ();

    cooldown_task_schedule_length dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .task_in(task_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    // Predictor state: letter histogram of the open job and the active cooldown.
    int unsigned letter_tally [NUM_KINDS];
    int unsigned tasks_held;
    bit          tasks_dropped;
    int unsigned cooldown_now;

    job_result_t pending_results [$];
    int          mismatches;
    int          rsp_hold;
    bit          calm;
    int          quiet_cycles;

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length drawn per request; calm stretches force back-to-back traffic.
    function automatic int idle_draw();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    // Shortest schedule of the open job under the current cooldown, saturated to the port.
    function automatic logic [LEN_W-1:0] schedule_slots();
        int unsigned     top;
        int unsigned     ties;
        int unsigned     total;
        int unsigned     c;
        longint unsigned frame;
        top   = 0;
        ties  = 0;
        total = 0;
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            c = letter_tally[k];
            total += c;
            if (c > top)
            begin
                top  = c;
                ties = 1;
            end
            else if (c != 0 && c == top)
            begin
                ties++;
            end
        end
        if (total == 0)
            return '0;
        frame = longint'(top - 1) * (longint'(cooldown_now) + 1) + ties;
        if (frame < total)
            frame = total;
        if (frame > longint'(LEN_MAX))
            frame = longint'(LEN_MAX);
        return frame[LEN_W-1:0];
    endfunction

    // Fold one accepted request into the histogram; a last request closes the job.
    function automatic void tally_task(input logic [LETTER_W-1:0] letter, input logic last);
        job_result_t job;
        if (letter < NUM_KINDS)
        begin
            if (tasks_held < MAX_TASKS)
            begin
                letter_tally[letter]++;
                tasks_held++;
            end
            else
            begin
                tasks_dropped = 1'b1;
            end
        end
        if (last)
        begin
            job.length   = schedule_slots();
            job.overflow = tasks_dropped;
            pending_results.push_back(job);
            foreach (letter_tally[k])
                letter_tally[k] = 0;
            tasks_held    = 0;
            tasks_dropped = 1'b0;
        end
    endfunction

    // Send one task request; called and returning at a falling edge.
    task automatic send_task(input logic [LETTER_W-1:0] letter, input logic last);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            task_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        task_ch.valid       <= 1'b1;
        task_ch.task_letter <= letter;
        task_ch.last_task   <= last;
        do
            @(posedge clk);
        while (!task_ch.ready);
        tally_task(letter, last);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic wait_drained();
        task_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Write the cooldown register once the block has gone quiet.
    task automatic write_cooldown(input int unsigned value);
        wait_drained();
        repeat (SETTLE_CYC) @(negedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.cooldown <= value[CD_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cooldown_now = value & 8'hFF;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random job: a skewed letter mix over a random alphabet, with some out-of-range noise.
    task automatic send_random_job(input int n_tasks);
        int          alphabet;
        int          heavy;
        logic [LETTER_W-1:0] letter;
        alphabet = $urandom_range(1, NUM_KINDS);
        heavy    = $urandom_range(0, alphabet - 1);
        for (int i = 0; i < n_tasks; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                letter = LETTER_W'($urandom_range(NUM_KINDS, 31));
            else if ($urandom_range(0, 99) < 35)
                letter = LETTER_W'(heavy);
            else
                letter = LETTER_W'($urandom_range(0, alphabet - 1));
            send_task(letter, i == n_tasks - 1);
        end
    endtask

    // Cooldown defaults to zero after reset; also empty jobs and out-of-range letters.
    task automatic test_reset_cooldown();
        send_task(LT_A, 1'b1);
        send_task(LT_TOP, 1'b1);
        send_task(LT_Z, 1'b0);
        send_task(5'd27, 1'b1);
        send_task(LT_A, 1'b0);
        send_task(LT_A, 1'b0);
        send_task(LT_B, 1'b0);
        send_task(LT_B, 1'b1);
    endtask

    // Small, large and extreme cooldowns on short hand-built jobs.
    task automatic test_cooldown_extremes();
        write_cooldown(2);
        repeat (3) send_task(LT_A, 1'b0);
        repeat (3) send_task(LT_B, 1'b0);
        send_task(LT_C, 1'b1);
        write_cooldown(255);
        send_task(LT_A, 1'b0);
        send_task(LT_A, 1'b1);
        send_task(LT_B, 1'b0);
        send_task(LT_OUT, 1'b0);
        send_task(LT_B, 1'b1);
        write_cooldown(1);
        send_task(LT_A, 1'b0);
        send_task(LT_B, 1'b0);
        send_task(LT_A, 1'b0);
        send_task(LT_C, 1'b1);
    endtask

    // A long back-to-back job with out-of-range noise, then a small job to show the clear.
    task automatic test_long_job();
        calm = 1'b1;
        write_cooldown(0);
        for (int i = 0; i < LONG_JOB; i++)
        begin
            if (i % 97 == 5)
                send_task(LT_TOP, 1'b0);
            send_task(LETTER_W'(i % NUM_KINDS), i == LONG_JOB - 1);
        end
        send_task(LT_C, 1'b1);
        calm = 1'b0;
    endtask

    // The sender holds off entirely until all outstanding results have arrived.
    task automatic test_drain_pause();
        write_cooldown(3);
        repeat (6) send_random_job($urandom_range(1, 5));
        wait_drained();
        repeat (6) send_random_job($urandom_range(1, 5));
    endtask

    // Random jobs over a sweep of cooldown settings.
    task automatic test_random_jobs();
        int unsigned cds [8];
        int          sent;
        int          n;
        cds = '{0, 1, 2, 255, 254, 7, 0, 0};
        cds[6] = $urandom_range(0, 255);
        cds[7] = $urandom_range(0, 31);
        foreach (cds[p])
        begin
            write_cooldown(cds[p]);
            sent = 0;
            while (sent < SWEEP_LEN)
            begin
                calm = ($urandom_range(0, 5) == 0);
                case ($urandom_range(0, 19))
                    0:       n = 1;
                    1, 2:    n = $urandom_range(13, 60);
                    default: n = $urandom_range(1, 12);
                endcase
                if (n == 1 && $urandom_range(0, 1) == 0)
                    send_task(LETTER_W'($urandom_range(NUM_KINDS, 31)), 1'b1);
                else
                    send_random_job(n);
                sent += n;
                if ($urandom_range(0, 14) == 0)
                    wait_drained();
            end
        end
        calm = 1'b0;
    endtask

    // Result receiver: stalls for a drawn number of cycles after each result.
    always @(negedge clk)
    begin
        if (rsp_hold > 0)
        begin
            result_ch.ready <= 1'b0;
            rsp_hold--;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected one.
    always @(posedge clk)
    begin : check_results
        job_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: schedule_length %0d overflow %0d",
                       result_ch.schedule_length, result_ch.overflow);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.schedule_length !== want.length)
                begin
                    $error("schedule_length: expected %0d, got %0d",
                           want.length, result_ch.schedule_length);
                    mismatches++;
                end
                if (result_ch.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0d, got %0d",
                           want.overflow, result_ch.overflow);
                    mismatches++;
                end
            end
            rsp_hold = idle_draw();
        end
    end

    // Watchdog: give up after too many cycles without any handshake on the task, cooldown or result channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((task_ch.valid && task_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_CAP)
            begin
                $display("FAIL cooldown_task_schedule_length");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        task_ch.valid       = 1'b0;
        task_ch.task_letter = '0;
        task_ch.last_task   = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.cooldown     = '0;
        result_ch.ready     = 1'b0;
        rsp_hold            = 0;
        calm                = 1'b0;
        mismatches          = 0;
        quiet_cycles        = 0;
        foreach (letter_tally[k])
            letter_tally[k] = 0;
        tasks_held    = 0;
        tasks_dropped = 1'b0;
        cooldown_now  = 0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_cooldown();
        test_cooldown_extremes();
        test_long_job();
        test_drain_pause();
        test_random_jobs();

        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("PASS cooldown_task_schedule_length");
        else
            $display("FAIL cooldown_task_schedule_length");
        $finish;
    end

endmodule
